// ----- design/masked_column_reduce_defines.svh -----
// Assertion macros used by the checker file of masked_column_reduce.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef MASKED_COLUMN_REDUCE_DEFINES_SVH
`define MASKED_COLUMN_REDUCE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define MCR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MCR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/mcr_pkg.sv -----
// Package for masked_column_reduce: field widths, command and mode codes,
// and the control and status bundles between controller and datapath.
// No dependencies.
package mcr_pkg;

  localparam int CMD_W      = 2;
  localparam int IDX_W      = 12;
  localparam int SMP_W      = 32;
  localparam int VAL_W      = 48;
  localparam int MODE_W     = 3;
  localparam int RSTART_W   = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;
  localparam int S_TDATA_W  = 80;
  localparam int M_TDATA_W  = 64;
  localparam int DIV_CNT_W  = $clog2(VAL_W + 1);

  localparam int DEPTH_DEF       = 4096;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam logic signed [VAL_W-1:0] ACC_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] ACC_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ACCUM = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_SUM       = 3'd0,
    MODE_MEAN      = 3'd1,
    MODE_MAX       = 3'd2,
    MODE_MIN       = 3'd3,
    MODE_RANK_DESC = 3'd4,
    MODE_RANK_ASC  = 3'd5
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE       = 1'd0,
    CFG_RANK_START = 1'd1
  } cfg_reg_e;

  typedef struct packed {
    logic capture;
    logic exec;
    logic div_start;
    logic out_load;
  } dp_ctl_t;

  typedef struct packed {
    logic is_read;
    logic need_div;
    logic div_done;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- design/mcr_ctrl.sv -----
// Controller of masked_column_reduce: sequences capture, execute, divide
// and output load for one item at a time. Depends on mcr_pkg.
module mcr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mcr_pkg::dp_stat_t stat_i,
  output mcr_pkg::dp_ctl_t  ctl_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          if (!stat_i.is_read) begin
            state_q <= ST_IDLE;
          end else if (stat_i.need_div) begin
            state_q <= ST_DIV;
          end else begin
            state_q <= ST_OUT;
          end
        end
        ST_DIV: begin
          if (stat_i.div_done) state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (stat_i.out_free) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    in_ready_o      = (state_q == ST_IDLE);
    ctl_o.capture   = (state_q == ST_IDLE) && in_valid_i;
    ctl_o.exec      = (state_q == ST_EXEC);
    ctl_o.div_start = (state_q == ST_EXEC) && stat_i.is_read && stat_i.need_div;
    ctl_o.out_load  = (state_q == ST_OUT) && stat_i.out_free;
  end

endmodule

// ----- design/mcr_div.sv -----
// Signed-by-unsigned restoring divider, one quotient bit per cycle,
// truncating toward zero. Depends on mcr_pkg.
module mcr_div #(
  parameter int COUNT_WIDTH = mcr_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic signed [mcr_pkg::VAL_W-1:0] dividend_i,
  input  logic [COUNT_WIDTH-1:0]         divisor_i,
  output logic                           done_o,
  output logic signed [mcr_pkg::VAL_W-1:0] quotient_o
);

  logic                           busy_q;
  logic                           done_q;
  logic [mcr_pkg::DIV_CNT_W-1:0]  cnt_q;
  logic [mcr_pkg::VAL_W-1:0]      quo_q;
  logic [COUNT_WIDTH-1:0]         rem_q;
  logic [COUNT_WIDTH-1:0]         dvs_q;
  logic                           neg_q;
  logic [COUNT_WIDTH:0]           rem_sh;
  logic [COUNT_WIDTH:0]           rem_sub;
  logic                           ge;

  always_comb begin
    rem_sh  = {rem_q, quo_q[mcr_pkg::VAL_W-1]};
    ge      = (rem_sh >= {1'b0, dvs_q});
    rem_sub = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= mcr_pkg::DIV_CNT_W'(mcr_pkg::VAL_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == mcr_pkg::DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[mcr_pkg::VAL_W-1];
      quo_q <= dividend_i[mcr_pkg::VAL_W-1] ? -dividend_i : dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[mcr_pkg::VAL_W-2:0], ge};
      rem_q <= rem_sub[COUNT_WIDTH-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? -quo_q : quo_q;

endmodule

// ----- design/mcr_datapath.sv -----
// Datapath of masked_column_reduce: configuration registers, per-position
// entry memory, combine logic, mean divider and output register.
// Depends on mcr_pkg and mcr_div.
module mcr_datapath #(
  parameter int DEPTH       = mcr_pkg::DEPTH_DEF,
  parameter int COUNT_WIDTH = mcr_pkg::COUNT_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [mcr_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [mcr_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic [mcr_pkg::CMD_W-1:0]         in_cmd_i,
  input  logic [mcr_pkg::IDX_W-1:0]         in_index_i,
  input  logic signed [mcr_pkg::SMP_W-1:0]  in_sample_i,
  input  logic                              in_sample_present_i,
  input  logic signed [mcr_pkg::SMP_W-1:0]  in_reference_i,
  input  logic                              in_reference_present_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [mcr_pkg::IDX_W-1:0]         out_result_index_o,
  output logic signed [mcr_pkg::VAL_W-1:0]  out_result_value_o,
  output logic                              out_result_present_o,
  input  mcr_pkg::dp_ctl_t                  ctl_i,
  output mcr_pkg::dp_stat_t                 stat_o
);

  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic signed [mcr_pkg::VAL_W-1:0] mem_acc  [DEPTH];
  logic                             mem_pres [DEPTH];
  logic [COUNT_WIDTH-1:0]           mem_cnt  [DEPTH];

  logic [mcr_pkg::MODE_W-1:0]       mode_q;
  logic [mcr_pkg::RSTART_W-1:0]     rank_start_q;

  logic [mcr_pkg::CMD_W-1:0]        cmd_q;
  logic [mcr_pkg::IDX_W-1:0]        idx_q;
  logic                             ok_q;
  logic signed [mcr_pkg::SMP_W-1:0] smp_q;
  logic                             sp_q;
  logic signed [mcr_pkg::SMP_W-1:0] ref_q;
  logic                             rp_q;

  logic signed [mcr_pkg::VAL_W-1:0] rd_acc_q;
  logic                             rd_pres_q;
  logic [COUNT_WIDTH-1:0]           rd_cnt_q;

  logic signed [mcr_pkg::VAL_W-1:0] pend_val_q;
  logic                             pend_pres_q;

  logic                             out_valid_q;
  logic [mcr_pkg::IDX_W-1:0]        out_idx_q;
  logic signed [mcr_pkg::VAL_W-1:0] out_val_q;
  logic                             out_pres_q;

  logic [AddrW-1:0]                 raddr;
  logic [AddrW-1:0]                 waddr;
  logic                             in_ok;
  logic signed [mcr_pkg::VAL_W-1:0] smp48;
  logic signed [mcr_pkg::VAL_W:0]   sum49;
  logic signed [mcr_pkg::VAL_W-1:0] sum_sat;
  logic signed [mcr_pkg::VAL_W-1:0] inc_sat;
  logic [COUNT_WIDTH-1:0]           cnt_base;
  logic [COUNT_WIDTH-1:0]           cnt_inc;
  logic [COUNT_WIDTH-1:0]           divisor;
  logic                             in_rank;

  logic                             wr_en;
  logic signed [mcr_pkg::VAL_W-1:0] wr_acc;
  logic                             wr_pres;
  logic [COUNT_WIDTH-1:0]           wr_cnt;
  logic signed [mcr_pkg::VAL_W-1:0] res_val;
  logic                             res_pres;
  logic                             need_div;

  logic                             div_done;
  logic signed [mcr_pkg::VAL_W-1:0] div_quo;

  assign in_ok = (32'(in_index_i) < 32'(DEPTH));
  assign raddr = in_ok ? AddrW'(in_index_i) : '0;
  assign waddr = AddrW'(idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= mcr_pkg::MODE_SUM;
      rank_start_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        mcr_pkg::CFG_MODE:       mode_q       <= cfg_wdata_i[mcr_pkg::MODE_W-1:0];
        mcr_pkg::CFG_RANK_START: rank_start_q <= cfg_wdata_i[mcr_pkg::RSTART_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      cmd_q     <= in_cmd_i;
      idx_q     <= in_index_i;
      ok_q      <= in_ok;
      smp_q     <= in_sample_i;
      sp_q      <= in_sample_present_i;
      ref_q     <= in_reference_i;
      rp_q      <= in_reference_present_i;
      rd_acc_q  <= mem_acc[raddr];
      rd_pres_q <= mem_pres[raddr];
      rd_cnt_q  <= mem_cnt[raddr];
    end
    if (ctl_i.exec && wr_en) begin
      mem_acc[waddr]  <= wr_acc;
      mem_pres[waddr] <= wr_pres;
      mem_cnt[waddr]  <= wr_cnt;
    end
  end

  always_comb begin
    smp48    = mcr_pkg::VAL_W'(smp_q);
    sum49    = (mcr_pkg::VAL_W + 1)'(rd_acc_q) + (mcr_pkg::VAL_W + 1)'(smp_q);
    if (sum49[mcr_pkg::VAL_W] != sum49[mcr_pkg::VAL_W-1]) begin
      sum_sat = sum49[mcr_pkg::VAL_W] ? mcr_pkg::ACC_MIN : mcr_pkg::ACC_MAX;
    end else begin
      sum_sat = sum49[mcr_pkg::VAL_W-1:0];
    end
    inc_sat  = (rd_acc_q == mcr_pkg::ACC_MAX) ? mcr_pkg::ACC_MAX : rd_acc_q + mcr_pkg::VAL_W'(1);
    cnt_base = rd_pres_q ? rd_cnt_q : '0;
    cnt_inc  = (cnt_base == {COUNT_WIDTH{1'b1}}) ? cnt_base : cnt_base + 1'b1;
    divisor  = (rd_cnt_q == '0) ? COUNT_WIDTH'(1) : rd_cnt_q;
    in_rank  = ({1'b0, idx_q} >= rank_start_q);
  end

  always_comb begin
    wr_en    = 1'b0;
    wr_acc   = rd_acc_q;
    wr_pres  = rd_pres_q;
    wr_cnt   = rd_cnt_q;
    res_val  = '0;
    res_pres = 1'b0;
    need_div = 1'b0;
    case (cmd_q)
      mcr_pkg::CMD_CLEAR: begin
        if (ok_q) begin
          wr_en   = 1'b1;
          wr_acc  = '0;
          wr_pres = 1'b0;
          wr_cnt  = '0;
        end
      end
      mcr_pkg::CMD_ACCUM: begin
        if (ok_q) begin
          wr_en = 1'b1;
          case (mode_q)
            mcr_pkg::MODE_SUM, mcr_pkg::MODE_MEAN: begin
              if (sp_q) begin
                wr_acc  = rd_pres_q ? sum_sat : smp48;
                wr_cnt  = cnt_inc;
                wr_pres = 1'b1;
              end
            end
            mcr_pkg::MODE_MAX: begin
              if (sp_q) begin
                if (!rd_pres_q || (smp48 > rd_acc_q)) wr_acc = smp48;
                wr_pres = 1'b1;
              end
            end
            mcr_pkg::MODE_MIN: begin
              if (sp_q) begin
                if (!rd_pres_q || (smp48 < rd_acc_q)) wr_acc = smp48;
                wr_pres = 1'b1;
              end
            end
            mcr_pkg::MODE_RANK_DESC: begin
              if (in_rank && sp_q && rp_q && (smp_q > ref_q)) wr_acc = inc_sat;
            end
            mcr_pkg::MODE_RANK_ASC: begin
              if (in_rank && sp_q && rp_q && (smp_q < ref_q)) wr_acc = inc_sat;
            end
            default: ;
          endcase
        end
      end
      mcr_pkg::CMD_READ: begin
        if (ok_q) begin
          case (mode_q)
            mcr_pkg::MODE_SUM, mcr_pkg::MODE_MAX, mcr_pkg::MODE_MIN: begin
              res_pres = rd_pres_q;
              res_val  = rd_pres_q ? rd_acc_q : '0;
            end
            mcr_pkg::MODE_MEAN: begin
              res_pres = rd_pres_q;
              need_div = rd_pres_q;
            end
            mcr_pkg::MODE_RANK_DESC, mcr_pkg::MODE_RANK_ASC: begin
              if (in_rank) begin
                res_pres = 1'b1;
                res_val  = inc_sat;
              end
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  mcr_div #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctl_i.div_start),
    .dividend_i (rd_acc_q),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i) begin
    if (ctl_i.exec) begin
      pend_val_q  <= res_val;
      pend_pres_q <= res_pres;
    end else if (div_done) begin
      pend_val_q  <= div_quo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      out_idx_q  <= idx_q;
      out_val_q  <= pend_val_q;
      out_pres_q <= pend_pres_q;
    end
  end

  always_comb begin
    stat_o.is_read  = (cmd_q == mcr_pkg::CMD_READ);
    stat_o.need_div = need_div;
    stat_o.div_done = div_done;
    stat_o.out_free = !out_valid_q || out_ready_i;
  end

  assign out_valid_o          = out_valid_q;
  assign out_result_index_o   = out_idx_q;
  assign out_result_value_o   = out_val_q;
  assign out_result_present_o = out_pres_q;

endmodule

// ----- design/masked_column_reduce.sv -----
// Per-position masked reduction (sum, mean, max, min, rank) over series.
// Top level joining mcr_ctrl and mcr_datapath; depends on mcr_pkg.
//
// Usage: items arrive on the s_axis channel, cmd in tuser and the other
// fields in tdata. Clear and accumulate commands update one entry and give
// no result. A read command gives one result on the m_axis channel.
// Configuration (mode, rank_start) is written on the cfg channel, which is
// always ready; write it only while the block is idle.
// Sequencing: one item is worked on at a time. A clear or accumulate is
// captured with its memory read, then written back. A read is captured,
// executed and then loaded into the output register, which raises
// m_axis_tvalid; a mean read waits before the load for the divider,
// which forms one quotient bit per cycle.
// Reset clears the controller, configuration and output valid; entries
// hold nothing defined until each is cleared by a clear command.
// When the receiver stalls, the result waits in the output register; the
// next item is still taken, and a following read waits until the output
// register is free.
module masked_column_reduce #(
  parameter int DEPTH       = mcr_pkg::DEPTH_DEF,
  parameter int COUNT_WIDTH = mcr_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mcr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [mcr_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // index[11:0], sample[43:12], sample_present[44], reference[76:45],
  // reference_present[77], zero pad[79:78]
  input  logic [mcr_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // cmd[1:0]
  input  logic [mcr_pkg::CMD_W-1:0]        s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // result_index[11:0], result_value[59:12], result_present[60],
  // zero pad[63:61]
  output logic [mcr_pkg::M_TDATA_W-1:0]    m_axis_tdata
);

  mcr_pkg::dp_ctl_t                 ctl;
  mcr_pkg::dp_stat_t                stat;
  logic [mcr_pkg::IDX_W-1:0]        res_index;
  logic signed [mcr_pkg::VAL_W-1:0] res_value;
  logic                             res_present;

  assign cfg_ready_o = 1'b1;

  mcr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .ctl_o      (ctl)
  );

  mcr_datapath #(
    .DEPTH       (DEPTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_valid_i            (cfg_valid_i),
    .cfg_index_i            (cfg_index_i),
    .cfg_wdata_i            (cfg_wdata_i),
    .in_cmd_i               (s_axis_tuser),
    .in_index_i             (s_axis_tdata[11:0]),
    .in_sample_i            (s_axis_tdata[43:12]),
    .in_sample_present_i    (s_axis_tdata[44]),
    .in_reference_i         (s_axis_tdata[76:45]),
    .in_reference_present_i (s_axis_tdata[77]),
    .out_ready_i            (m_axis_tready),
    .out_valid_o            (m_axis_tvalid),
    .out_result_index_o     (res_index),
    .out_result_value_o     (res_value),
    .out_result_present_o   (res_present),
    .ctl_i                  (ctl),
    .stat_o                 (stat)
  );

  assign m_axis_tdata = {3'b000, res_present, res_value, res_index};

endmodule

// ----- design/mcr_checker.sv -----
// Port-level checker for masked_column_reduce, bound to the top level.
// Depends on masked_column_reduce_defines.svh and mcr_pkg.
`include "masked_column_reduce_defines.svh"

module mcr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [mcr_pkg::CMD_W-1:0]     s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [mcr_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  logic in_xfer;
  logic stall;
  logic empty_out;
  logic no_res;

  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign stall     = m_axis_tvalid && !m_axis_tready;
  assign empty_out = m_axis_tvalid && !m_axis_tdata[60];
  assign no_res    = in_xfer && (s_axis_tuser != mcr_pkg::CMD_READ);

  `MCR_ASSERT_NEXT(a_out_hold, stall, m_axis_tvalid && $stable(m_axis_tdata), "result not held")
  `MCR_ASSERT_NEXT(a_one_item, in_xfer, !s_axis_tready, "input taken while an item is in work")
  `MCR_ASSERT_SAME(a_empty_zero, empty_out, m_axis_tdata[59:12] == '0, "nonzero empty result")
  `MCR_ASSERT_NEXT(a_no_spurious, no_res, !$rose(m_axis_tvalid), "result after no-result item")

endmodule

bind masked_column_reduce mcr_checker u_mcr_checker (.*);
